>>> design/tve_pkg.sv
// ----------------------------------------------------------------------------
// tve_pkg
// Types and constants shared by the ternary vector engine: command codes,
// control states and the packed beats of the input and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

package tve_pkg;

  localparam int COUNT_W = 11;
  localparam int FIELD_W = 64;
  localparam int INDEX_W = 4;

  localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1024;

  typedef enum logic [2:0] {
    CMD_CLEAR   = 3'd0,
    CMD_LOAD    = 3'd1,
    CMD_COMPARE = 3'd2,
    CMD_MERGE   = 3'd3,
    CMD_COPY    = 3'd4,
    CMD_FIX_X   = 3'd5,
    CMD_COUNT_X = 3'd6,
    CMD_READ    = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_POST
  } state_t;

  typedef struct packed {
    cmd_t                command;
    logic [INDEX_W-1:0]  word_index;
    logic                last_word;
    logic [FIELD_W-1:0]  other_zero;
    logic [FIELD_W-1:0]  other_one;
    logic [FIELD_W-1:0]  data_bits;
  } in_beat_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  word_zero;
    logic [FIELD_W-1:0]  word_one;
    logic [COUNT_W-1:0]  x_count;
    logic                is_equal;
    logic                is_covered;
    logic                is_strictly_covered;
    logic                has_conflict;
    logic                merge_done;
  } out_beat_t;

endpackage

`default_nettype wire

>>> design/ternary_vector_engine_top.sv
// ----------------------------------------------------------------------------
// ternary_vector_engine_top
// Three-valued vector held as a zero plane and a one plane in one word memory,
// with a staging memory for merge operands. Word commands read one word; load,
// copy and fix_x write it back; count_x and a committing merge walk every word.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_ready  | in_beat  (tve_pkg::in_beat_t)
//   out_    | output    | out_valid/out_ready| out_beat (tve_pkg::out_beat_t)
//   cfg_    | input     | cfg_wr_en          | cfg_wr_data (position count)
//
// A word command reads the plane memory as its beat is taken, then modifies and
// writes back; the next beat is taken while the result is handed over. count_x
// and a committing merge walk the memory, reading each word while the previous one
// is folded in. Reset clears per-word valid bits, so unwritten words read as X.
// A stalled result register holds the block; input is closed until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module ternary_vector_engine_top #(
  parameter int WORD_BITS = 64,
  parameter int MAX_WORDS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tve_pkg::in_beat_t             in_beat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tve_pkg::out_beat_t            out_beat,
  input  logic                          cfg_wr_en,
  input  logic [tve_pkg::COUNT_W-1:0]   cfg_wr_data
);
  import tve_pkg::*;

  localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int PW  = $clog2(MAX_WORDS + 1);
  localparam int LW  = $clog2(128 * WORD_BITS) + 1;
  localparam int PLW = 2 * WORD_BITS;
  localparam logic [LW-1:0] CAP = LW'(MAX_WORDS * WORD_BITS);

  function automatic logic [WORD_BITS-1:0] word_mask(input logic [6:0] w,
                                                     input logic [LW-1:0] cnt);
    logic [LW-1:0] lo;
    logic [LW-1:0] rem;
    begin
      lo  = LW'(w) * LW'(WORD_BITS);
      rem = cnt - lo;
      if (cnt <= lo) begin
        word_mask = '0;
      end else if (rem >= LW'(WORD_BITS)) begin
        word_mask = '1;
      end else begin
        word_mask = ~({WORD_BITS{1'b1}} << rem);
      end
    end
  endfunction

  // storage
  logic [PLW-1:0]       plane_mem [MAX_WORDS];
  logic [PLW-1:0]       stage_mem [MAX_WORDS];
  logic [MAX_WORDS-1:0] pl_vld_r;
  logic [PLW-1:0]       pl_rd_r;
  logic [PLW-1:0]       st_rd_r;
  logic                 rd_vld_r;

  // control and payload registers
  state_t               state_r, state_nxt;
  in_beat_t             item_r;
  out_beat_t            res_r, res_nxt;
  out_beat_t            out_r;
  logic                 out_valid_r;
  logic [COUNT_W-1:0]   cfg_count_r;
  logic                 seen_conflict_r, seen_conflict_nxt;
  logic                 all_same_r, all_same_nxt;
  logic                 all_covered_r, all_covered_nxt;
  logic [PW-1:0]        walk_rd_r, walk_rd_nxt;
  logic [AW-1:0]        walk_wr_r, walk_wr_nxt;
  logic                 walk_dv_r, walk_dv_nxt;
  logic                 walk_cnt_r, walk_cnt_nxt;
  logic [LW-1:0]        acc_r, acc_nxt;

  // memory port controls
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 pl_we;
  logic                 st_we;
  logic [AW-1:0]        wr_addr;
  logic [PLW-1:0]       pl_wd;
  logic                 clr_all;
  logic                 post;
  logic                 out_free;

  // address and mask helpers
  logic [31:0]          in_idx_ext;
  logic [31:0]          item_idx_ext;
  logic [AW-1:0]        in_addr;
  logic [AW-1:0]        item_addr;
  logic                 item_inr;
  logic [LW-1:0]        eff_cnt;

  // execute datapath
  logic [WORD_BITS-1:0] vm, sz, so, bz, bo, dd, cp_m, fx_m;
  logic                 w_same, w_cover, w_conf;
  logic                 conf_all;

  // walk datapath
  logic [WORD_BITS-1:0] wm, wz, wo, mz, mo;
  logic [LW-1:0]        pc;

  assign in_idx_ext   = 32'(in_beat.word_index);
  assign item_idx_ext = 32'(item_r.word_index);
  assign in_addr      = in_idx_ext[AW-1:0];
  assign item_addr    = item_idx_ext[AW-1:0];
  assign item_inr     = (item_idx_ext < 32'(MAX_WORDS));
  assign eff_cnt      = (LW'(cfg_count_r) > CAP) ? CAP : LW'(cfg_count_r);
  assign out_free     = !out_valid_r || out_ready;

  assign vm = word_mask(7'(item_r.word_index), eff_cnt);
  assign sz = pl_rd_r[PLW-1:WORD_BITS] & {WORD_BITS{rd_vld_r}} & vm;
  assign so = pl_rd_r[WORD_BITS-1:0] & {WORD_BITS{rd_vld_r}} & vm;
  assign bz = item_r.other_zero[WORD_BITS-1:0] & vm;
  assign bo = item_r.other_one[WORD_BITS-1:0] & vm;
  assign dd = item_r.data_bits[WORD_BITS-1:0];

  assign w_same   = (sz == bz) && (so == bo);
  assign w_cover  = ((~sz & bz) == '0) && ((~so & bo) == '0);
  assign w_conf   = |((sz ^ bz) & (so ^ bo));
  assign conf_all = seen_conflict_r | w_conf;
  assign cp_m     = bz | bo;
  assign fx_m     = ~(sz | so) & vm;

  assign wm = word_mask(7'(walk_wr_r), eff_cnt);
  assign wz = pl_rd_r[PLW-1:WORD_BITS] & {WORD_BITS{rd_vld_r}};
  assign wo = pl_rd_r[WORD_BITS-1:0] & {WORD_BITS{rd_vld_r}};
  assign mz = (wz | st_rd_r[PLW-1:WORD_BITS]) & wm;
  assign mo = (wo | st_rd_r[WORD_BITS-1:0]) & wm;
  assign pc = LW'($countones((wz | wo) & wm));

  always_comb begin
    state_nxt         = state_r;
    res_nxt           = res_r;
    seen_conflict_nxt = seen_conflict_r;
    all_same_nxt      = all_same_r;
    all_covered_nxt   = all_covered_r;
    walk_rd_nxt       = walk_rd_r;
    walk_wr_nxt       = walk_wr_r;
    walk_dv_nxt       = 1'b0;
    walk_cnt_nxt      = walk_cnt_r;
    acc_nxt           = acc_r;
    rd_en             = 1'b0;
    rd_addr           = in_addr;
    pl_we             = 1'b0;
    st_we             = 1'b0;
    wr_addr           = item_addr;
    pl_wd             = '0;
    clr_all           = 1'b0;
    post              = 1'b0;
    in_ready          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rd_en     = 1'b1;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_nxt   = '0;
        state_nxt = ST_POST;
        case (item_r.command)
          CMD_CLEAR: begin
            clr_all = 1'b1;
          end
          CMD_LOAD: begin
            pl_we = item_inr;
            pl_wd = {~dd & vm, dd & vm};
          end
          CMD_COMPARE: begin
            all_same_nxt      = all_same_r & w_same;
            all_covered_nxt   = all_covered_r & w_cover;
            seen_conflict_nxt = conf_all;
            if (item_r.last_word) begin
              res_nxt.is_equal            = all_same_nxt;
              res_nxt.is_covered          = all_covered_nxt;
              res_nxt.is_strictly_covered = all_covered_nxt && !all_same_nxt;
              res_nxt.has_conflict        = conf_all;
              seen_conflict_nxt           = 1'b0;
              all_same_nxt                = 1'b1;
              all_covered_nxt             = 1'b1;
            end
          end
          CMD_MERGE: begin
            st_we             = item_inr;
            seen_conflict_nxt = conf_all;
            if (item_r.last_word) begin
              res_nxt.has_conflict = conf_all;
              seen_conflict_nxt    = 1'b0;
              all_same_nxt         = 1'b1;
              all_covered_nxt      = 1'b1;
              if (!conf_all) begin
                walk_cnt_nxt = 1'b0;
                walk_rd_nxt  = '0;
                acc_nxt      = '0;
                state_nxt    = ST_WALK;
              end
            end
          end
          CMD_COPY: begin
            pl_we = item_inr;
            pl_wd = {(sz & ~cp_m) | bz, (so & ~cp_m) | bo};
          end
          CMD_FIX_X: begin
            pl_we = item_inr;
            pl_wd = {sz | (~dd & fx_m), so | (dd & fx_m)};
          end
          CMD_COUNT_X: begin
            walk_cnt_nxt = 1'b1;
            walk_rd_nxt  = '0;
            acc_nxt      = '0;
            state_nxt    = ST_WALK;
          end
          CMD_READ: begin
            res_nxt.word_zero = FIELD_W'(sz);
            res_nxt.word_one  = FIELD_W'(so);
          end
          default: ;
        endcase
      end

      ST_WALK: begin
        // issue the next read while the previous word is folded in
        if (walk_rd_r < PW'(MAX_WORDS)) begin
          rd_en       = 1'b1;
          rd_addr     = walk_rd_r[AW-1:0];
          walk_rd_nxt = walk_rd_r + 1'b1;
          walk_wr_nxt = walk_rd_r[AW-1:0];
          walk_dv_nxt = 1'b1;
        end
        if (walk_dv_r) begin
          wr_addr = walk_wr_r;
          if (walk_cnt_r) begin
            acc_nxt = acc_r + pc;
          end else begin
            pl_we = 1'b1;
            pl_wd = {mz, mo};
          end
          if (walk_wr_r == AW'(MAX_WORDS - 1)) begin
            state_nxt = ST_POST;
            if (walk_cnt_r) begin
              res_nxt.x_count = COUNT_W'(eff_cnt - acc_r - pc);
            end else begin
              res_nxt.merge_done = 1'b1;
            end
          end
        end
      end

      ST_POST: begin
        if (out_free) begin
          post     = 1'b1;
          in_ready = 1'b1;
          if (in_valid) begin
            rd_en     = 1'b1;
            state_nxt = ST_EXEC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      cfg_count_r     <= COUNT_RST;
      seen_conflict_r <= 1'b0;
      all_same_r      <= 1'b1;
      all_covered_r   <= 1'b1;
      walk_dv_r       <= 1'b0;
      pl_vld_r        <= '0;
    end else begin
      state_r         <= state_nxt;
      seen_conflict_r <= seen_conflict_nxt;
      all_same_r      <= all_same_nxt;
      all_covered_r   <= all_covered_nxt;
      walk_dv_r       <= walk_dv_nxt;
      if (cfg_wr_en) begin
        cfg_count_r <= cfg_wr_data;
      end
      if (post) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (clr_all) begin
        pl_vld_r <= '0;
      end else if (pl_we) begin
        pl_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    walk_rd_r  <= walk_rd_nxt;
    walk_wr_r  <= walk_wr_nxt;
    walk_cnt_r <= walk_cnt_nxt;
    acc_r      <= acc_nxt;
    if (in_valid && in_ready) begin
      item_r <= in_beat;
    end
    if (post) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pl_we) begin
      plane_mem[wr_addr] <= pl_wd;
    end
    if (st_we) begin
      stage_mem[wr_addr] <= {bz, bo};
    end
    if (rd_en) begin
      pl_rd_r  <= plane_mem[rd_addr];
      st_rd_r  <= stage_mem[rd_addr];
      rd_vld_r <= pl_vld_r[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> walk_rd_r <= PW'(MAX_WORDS))
    else $error("walk read counter past last word");

  a_walk_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK || state_r == ST_EXEC) |-> !in_ready)
    else $error("input beat taken during execute or walk");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_POST) |-> !pl_we && !st_we && !clr_all)
    else $error("memory write outside execute or walk");

  a_post_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_POST)
    else $error("result beat raised outside post state");

endmodule

`default_nettype wire

>>> tb/ternary_vector_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ternary_vector_engine_top_tb
// Self-checking bench for the ternary vector engine. A bit-accurate model of
// the two planes, the merge staging and the compare/merge flags predicts each
// result beat. Directed tests cover every command, the valid mask and mixed
// compare/merge. Random phases follow under several position counts, with
// random gaps on both channels, a long result stall and drain pauses.
// ----------------------------------------------------------------------------
module ternary_vector_engine_top_tb;
  import tve_pkg::*;

  localparam int NWORDS        = 16;
  localparam int NBITS         = FIELD_W;
  localparam int CAPACITY      = NWORDS * NBITS;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = NWORDS + 8;
  localparam int PHASE_ITEMS   = 176;
  localparam int STALL_ITEMS   = 66;

  typedef enum int {
    OPD_EQUAL,
    OPD_SUBSET,
    OPD_COMPAT,
    OPD_CONFLICT,
    OPD_NOISE
  } opd_kind_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_beat_t           in_beat;
  logic               out_valid;
  logic               out_ready;
  out_beat_t          out_beat;
  logic               cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;

  logic [NBITS-1:0]   vec_zero   [NWORDS];
  logic [NBITS-1:0]   vec_one    [NWORDS];
  logic [NBITS-1:0]   stage_zero [NWORDS];
  logic [NBITS-1:0]   stage_one  [NWORDS];
  logic               acc_conflict;
  logic               acc_same;
  logic               acc_covered;
  logic [COUNT_W-1:0] pos_count;

  out_beat_t pending_q[$];
  int        err_count      = 0;
  int        cycle_count    = 0;
  bit        tx_idle        = 1'b1;
  bit        rx_idle        = 1'b1;
  int        rx_hold_cycles = 0;

  ternary_vector_engine_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_beat     (in_beat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_beat    (out_beat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ternary_vector_engine_top_tb NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Vector model
  // --------------------------------------------------------------------------
  function automatic void clear_flags();
    acc_conflict = 1'b0;
    acc_same     = 1'b1;
    acc_covered  = 1'b1;
  endfunction

  function automatic void reset_vector();
    for (int i = 0; i < NWORDS; i++) begin
      vec_zero[i]   = '0;
      vec_one[i]    = '0;
      stage_zero[i] = '0;
      stage_one[i]  = '0;
    end
    clear_flags();
    pos_count = COUNT_RST;
  endfunction

  function automatic int live_count();
    return (int'(pos_count) > CAPACITY) ? CAPACITY : int'(pos_count);
  endfunction

  function automatic logic [NBITS-1:0] live_mask(int w);
    int cnt;
    int lo;
    cnt = live_count();
    lo  = w * NBITS;
    if (cnt <= lo) return '0;
    if (cnt - lo >= NBITS) return '1;
    return (64'd1 << (cnt - lo)) - 64'd1;
  endfunction

  function automatic out_beat_t predict_beat(in_beat_t b);
    out_beat_t        r;
    logic [NBITS-1:0] vm;
    logic [NBITS-1:0] sz;
    logic [NBITS-1:0] so;
    logic [NBITS-1:0] bz;
    logic [NBITS-1:0] bo;
    logic [NBITS-1:0] m;
    int               w;
    int               n;
    w  = int'(b.word_index);
    vm = live_mask(w);
    sz = vec_zero[w] & vm;
    so = vec_one[w] & vm;
    bz = b.other_zero & vm;
    bo = b.other_one & vm;
    r  = '0;
    case (b.command)
      CMD_CLEAR: begin
        for (int i = 0; i < NWORDS; i++) begin
          vec_zero[i] = '0;
          vec_one[i]  = '0;
        end
      end
      CMD_LOAD: begin
        vec_zero[w] = ~b.data_bits & vm;
        vec_one[w]  = b.data_bits & vm;
      end
      CMD_COMPARE: begin
        if (sz != bz || so != bo) acc_same = 1'b0;
        if ((~sz & bz) != '0 || (~so & bo) != '0) acc_covered = 1'b0;
        if (((sz ^ bz) & (so ^ bo)) != '0) acc_conflict = 1'b1;
        if (b.last_word) begin
          r.is_equal            = acc_same;
          r.is_covered          = acc_covered;
          r.is_strictly_covered = acc_covered && !acc_same;
          r.has_conflict        = acc_conflict;
          clear_flags();
        end
      end
      CMD_MERGE: begin
        stage_zero[w] = bz;
        stage_one[w]  = bo;
        if (((sz ^ bz) & (so ^ bo)) != '0) acc_conflict = 1'b1;
        if (b.last_word) begin
          r.has_conflict = acc_conflict;
          if (!acc_conflict) begin
            for (int i = 0; i < NWORDS; i++) begin
              m           = live_mask(i);
              vec_zero[i] = (vec_zero[i] | stage_zero[i]) & m;
              vec_one[i]  = (vec_one[i] | stage_one[i]) & m;
            end
            r.merge_done = 1'b1;
          end
          clear_flags();
        end
      end
      CMD_COPY: begin
        m           = bz | bo;
        vec_zero[w] = ((sz & ~m) | bz) & vm;
        vec_one[w]  = ((so & ~m) | bo) & vm;
      end
      CMD_FIX_X: begin
        m           = ~(sz | so) & vm;
        vec_zero[w] = (sz | (~b.data_bits & m)) & vm;
        vec_one[w]  = (so | (b.data_bits & m)) & vm;
      end
      CMD_COUNT_X: begin
        n = 0;
        for (int i = 0; i < NWORDS; i++)
          n += $countones((vec_zero[i] | vec_one[i]) & live_mask(i));
        r.x_count = COUNT_W'(live_count() - n);
      end
      CMD_READ: begin
        r.word_zero = sz;
        r.word_one  = so;
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [NBITS-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_beat_t beat_of(cmd_t c, int w, bit last, logic [NBITS-1:0] oz,
                                       logic [NBITS-1:0] oo, logic [NBITS-1:0] d);
    in_beat_t b;
    b.command    = c;
    b.word_index = INDEX_W'(w);
    b.last_word  = last;
    b.other_zero = oz;
    b.other_one  = oo;
    b.data_bits  = d;
    return b;
  endfunction

  function automatic int pick_word();
    int live_words;
    live_words = (live_count() + NBITS - 1) / NBITS;
    if (live_words == 0 || $urandom_range(0, 4) == 0) return $urandom_range(0, NWORDS - 1);
    return $urandom_range(0, live_words - 1);
  endfunction

  function automatic opd_kind_t pick_kind(bit merging);
    int r;
    r = $urandom_range(0, 99);
    if (merging) begin
      if (r < 65) return OPD_COMPAT;
      if (r < 75) return OPD_SUBSET;
      if (r < 80) return OPD_EQUAL;
      if (r < 90) return OPD_CONFLICT;
      return OPD_NOISE;
    end
    if (r < 25) return OPD_EQUAL;
    if (r < 50) return OPD_SUBSET;
    if (r < 70) return OPD_COMPAT;
    if (r < 85) return OPD_CONFLICT;
    return OPD_NOISE;
  endfunction

  // build an operand relative to the stored word so flags and commits get exercised
  function automatic in_beat_t make_beat(cmd_t c, int w, bit last, opd_kind_t k);
    logic [NBITS-1:0] z;
    logic [NBITS-1:0] o;
    logic [NBITS-1:0] xs;
    logic [NBITS-1:0] keep;
    logic [NBITS-1:0] fill;
    logic [NBITS-1:0] r;
    in_beat_t         b;
    int               top;
    int               p;
    z    = vec_zero[w];
    o    = vec_one[w];
    xs   = ~(z | o);
    keep = rand64() | (z & o);
    fill = rand64();
    r    = rand64();
    b    = beat_of(c, w, last, z, o, rand64());
    case (k)
      OPD_SUBSET: begin
        b.other_zero = z & keep;
        b.other_one  = o & keep;
      end
      OPD_COMPAT: begin
        b.other_zero = (z & keep) | (xs & fill & r);
        b.other_one  = (o & keep) | (xs & fill & ~r);
      end
      OPD_CONFLICT: begin
        top = live_count() - w * NBITS - 1;
        if (top > NBITS - 1 || top < 0) top = NBITS - 1;
        p = $urandom_range(0, top);
        b.other_zero[p] = ~z[p];
        b.other_one[p]  = ~o[p];
      end
      OPD_NOISE: begin
        b.other_zero = rand64();
        b.other_one  = rand64();
      end
      default: ;
    endcase
    return b;
  endfunction

  task automatic send_beat(in_beat_t b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(predict_beat(b));
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [COUNT_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    pos_count = v;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report_mismatch(string what, logic [NBITS-1:0] got, logic [NBITS-1:0] want);
    err_count++;
    if (err_count <= 40)
      $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Result channel: random stall per beat, long hold on request, check
  // --------------------------------------------------------------------------
  initial begin : result_sink
    out_beat_t want;
    int        stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = rx_idle ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_q.size() == 0) begin
        report_mismatch("result beat with none pending", out_beat.word_zero, '0);
      end else begin
        want = pending_q.pop_front();
        if (out_beat.word_zero !== want.word_zero)
          report_mismatch("word_zero", out_beat.word_zero, want.word_zero);
        if (out_beat.word_one !== want.word_one)
          report_mismatch("word_one", out_beat.word_one, want.word_one);
        if (out_beat.x_count !== want.x_count)
          report_mismatch("x_count", NBITS'(out_beat.x_count), NBITS'(want.x_count));
        if (out_beat.is_equal !== want.is_equal)
          report_mismatch("is_equal", NBITS'(out_beat.is_equal), NBITS'(want.is_equal));
        if (out_beat.is_covered !== want.is_covered)
          report_mismatch("is_covered", NBITS'(out_beat.is_covered),
                          NBITS'(want.is_covered));
        if (out_beat.is_strictly_covered !== want.is_strictly_covered)
          report_mismatch("is_strictly_covered", NBITS'(out_beat.is_strictly_covered),
                          NBITS'(want.is_strictly_covered));
        if (out_beat.has_conflict !== want.has_conflict)
          report_mismatch("has_conflict", NBITS'(out_beat.has_conflict),
                          NBITS'(want.has_conflict));
        if (out_beat.merge_done !== want.merge_done)
          report_mismatch("merge_done", NBITS'(out_beat.merge_done),
                          NBITS'(want.merge_done));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_load_read();
    send_beat(beat_of(CMD_LOAD, 0, 1'b0, '1, '1, '1));
    send_beat(beat_of(CMD_LOAD, NWORDS - 1, 1'b1, '0, '0, '0));
    send_beat(beat_of(CMD_READ, 0, 1'b0, '0, '0, '0));
    send_beat(beat_of(CMD_READ, NWORDS - 1, 1'b0, '0, '0, '0));
  endtask

  task automatic test_copy_fix();
    send_beat(beat_of(CMD_COPY, 3, 1'b0, '1, rand64(), '0));
    send_beat(beat_of(CMD_COPY, 4, 1'b0, rand64(), rand64(), '0));
    send_beat(beat_of(CMD_FIX_X, 4, 1'b0, '0, '0, '1));
    send_beat(beat_of(CMD_READ, 4, 1'b0, '0, '0, '0));
    send_beat(beat_of(CMD_COUNT_X, 0, 1'b0, '0, '0, '0));
  endtask

  task automatic test_compare();
    send_beat(make_beat(CMD_COMPARE, 0, 1'b1, OPD_EQUAL));
    // all-X operand against a defined word: strictly covered
    send_beat(beat_of(CMD_COMPARE, 0, 1'b1, '0, '0, '1));
    send_beat(make_beat(CMD_COMPARE, NWORDS - 1, 1'b1, OPD_CONFLICT));
  endtask

  // stage every word so later commits never read an unwritten staging entry
  task automatic test_merge_commit();
    for (int w = 0; w < NWORDS; w++)
      send_beat(make_beat(CMD_MERGE, w, w == NWORDS - 1, OPD_COMPAT));
  endtask

  task automatic test_mixed_flags();
    send_beat(make_beat(CMD_MERGE, 3, 1'b0, OPD_CONFLICT));
    send_beat(make_beat(CMD_COMPARE, 0, 1'b1, OPD_EQUAL));
    send_beat(make_beat(CMD_MERGE, 1, 1'b1, OPD_CONFLICT));
  endtask

  task automatic test_valid_mask();
    wait_results_drained();
    write_count(COUNT_W'(70));
    send_beat(beat_of(CMD_LOAD, 1, 1'b0, '0, '0, '1));
    send_beat(beat_of(CMD_READ, 1, 1'b0, '0, '0, '0));
    send_beat(beat_of(CMD_COUNT_X, 0, 1'b0, '0, '0, '0));
    wait_results_drained();
    write_count('0);
    send_beat(beat_of(CMD_READ, 0, 1'b0, '0, '0, '0));
    send_beat(beat_of(CMD_COMPARE, 0, 1'b1, rand64(), rand64(), '0));
    wait_results_drained();
    write_count('1);
    send_beat(beat_of(CMD_COUNT_X, 0, 1'b0, '0, '0, '0));
    send_beat(beat_of(CMD_CLEAR, 0, 1'b0, '0, '0, '0));
    send_beat(beat_of(CMD_COUNT_X, 0, 1'b0, '0, '0, '0));
    wait_results_drained();
  endtask

  task automatic send_random_group(output int n);
    int   sel;
    int   len;
    cmd_t c;
    sel = $urandom_range(0, 99);
    n   = 0;
    if (sel < 30) begin
      case ($urandom_range(0, 3))
        0:       c = CMD_LOAD;
        1:       c = CMD_COPY;
        2:       c = CMD_FIX_X;
        default: c = CMD_READ;
      endcase
      send_beat(make_beat(c, pick_word(), 1'($urandom_range(0, 1)), pick_kind(1'b1)));
      n = 1;
    end else if (sel < 55 || sel < 75) begin
      c   = (sel < 55) ? CMD_COMPARE : CMD_MERGE;
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++)
        send_beat(make_beat(c, pick_word(), i == len - 1, pick_kind(c == CMD_MERGE)));
      n = len;
    end else if (sel < 80) begin
      send_beat(beat_of(CMD_CLEAR, $urandom_range(0, NWORDS - 1), 1'($urandom_range(0, 1)),
                        rand64(), rand64(), rand64()));
      n = 1;
    end else if (sel < 88) begin
      send_beat(beat_of(CMD_COUNT_X, $urandom_range(0, NWORDS - 1), 1'($urandom_range(0, 1)),
                        rand64(), rand64(), rand64()));
      n = 1;
    end else begin
      send_beat(beat_of(cmd_t'($urandom_range(0, 7)), $urandom_range(0, NWORDS - 1),
                        1'($urandom_range(0, 1)), rand64(), rand64(), rand64()));
      n = 1;
    end
  endtask

  task automatic run_random_items(int n_items);
    int sent;
    int n;
    sent = 0;
    while (sent < n_items) begin
      send_random_group(n);
      sent += n;
    end
  endtask

  task automatic test_random_phases();
    int phase_count[9];
    phase_count = '{1024, 1, 2047, 0, 64, 65, $urandom_range(2, 1023),
                    $urandom_range(1025, 2046), 1024};
    for (int p = 0; p < 9; p++) begin
      // pause until every pending result is back, then retune
      wait_results_drained();
      write_count(COUNT_W'(phase_count[p]));
      tx_idle = (p % 3) != 1;
      rx_idle = (p % 3) != 2 && (p % 3) != 1;
      if (p == 8) rx_idle = 1'b1;
      run_random_items(PHASE_ITEMS);
    end
  endtask

  task automatic test_result_stall();
    wait_results_drained();
    tx_idle        = 1'b0;
    rx_idle        = 1'b1;
    // hold off the result channel and keep offering beats to back up the engine
    rx_hold_cycles = 400;
    run_random_items(STALL_ITEMS);
    tx_idle = 1'b1;
  endtask

  initial begin : main_seq
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_beat     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    reset_vector();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_read();
    test_copy_fix();
    test_compare();
    test_merge_commit();
    test_mixed_flags();
    test_valid_mask();
    test_random_phases();
    test_result_stall();

    wait_results_drained();
    if (err_count == 0 && pending_q.size() == 0) begin
      $display("ternary_vector_engine_top_tb OK");
    end else begin
      $display("ternary_vector_engine_top_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/tve_pkg.sv
design/ternary_vector_engine_top.sv
tb/ternary_vector_engine_top_tb.sv
